>>> rtl/kwlex_pkg.sv
`default_nettype none

package kwlex_pkg;

   // Widths of the token text bookkeeping, wide enough for the largest buffer
   localparam int TEXT_LEN_W = 6;

   // Token types
   localparam logic [3:0] TOK_IDENT  = 4'd6;
   localparam logic [3:0] TOK_NUMBER = 4'd7;
   localparam logic [3:0] TOK_STRING = 4'd8;
   localparam logic [3:0] TOK_ASSIGN = 4'd9;
   localparam logic [3:0] TOK_OP     = 4'd10;
   localparam logic [3:0] TOK_COLON  = 4'd11;
   localparam logic [3:0] TOK_EOF    = 4'd12;

   // Characters with a meaning of their own
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // Keyword table: token type of keyword k is k
   localparam int KW_COUNT   = 6;
   localparam int KW_MAX_LEN = 8;
   localparam int KW_POS_W   = 3;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{"l", "e", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"s", "a", "y", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"p", "r", "o", "v", "i", "d", "e", CH_NUL},
      '{"w", "h", "e", "n", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"n", "o", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"e", "n", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
   };

   localparam logic [TEXT_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      6'd3, 6'd3, 6'd7, 6'd4, 6'd3, 6'd3
   };

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // Lexer modes
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUM,
      MODE_STR,
      MODE_EQ,
      MODE_BANG,
      MODE_GT,
      MODE_LT
   } mode_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_SEND
   } back_state_type;

   // Operations handed from front to back
   typedef enum logic [1:0] {
      UOP_APPEND,  // write data at buffer index len
      UOP_CHAR,    // one result from data
      UOP_TEXT     // run of len results read from the buffer
   } uop_kind_type;

   typedef struct packed {
      uop_kind_type          kind;
      logic [3:0]            token_type;
      logic [7:0]            data;
      logic                  text_valid;
      logic [TEXT_LEN_W-1:0] len;
      logic                  trunc;
      logic                  token_last;
      logic                  step_last;
   } uop_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

   function automatic uop_type make_append(input logic [TEXT_LEN_W-1:0] idx,
                                           input logic [7:0] c);
      uop_type u;
      u = '0;
      u.kind = UOP_APPEND;
      u.data = c;
      u.len  = idx;
      return u;
   endfunction

   function automatic uop_type make_char(input logic [3:0] tt, input logic [7:0] c,
                                         input logic valid, input logic last);
      uop_type u;
      u = '0;
      u.kind       = UOP_CHAR;
      u.token_type = tt;
      u.data       = c;
      u.text_valid = valid;
      u.token_last = last;
      return u;
   endfunction

   function automatic uop_type make_text(input logic [3:0] tt,
                                         input logic [TEXT_LEN_W-1:0] len,
                                         input logic trunc);
      uop_type u;
      u = '0;
      u.kind       = UOP_TEXT;
      u.token_type = tt;
      u.text_valid = (len != '0);
      u.len        = len;
      u.trunc      = trunc;
      u.token_last = 1'b1;
      return u;
   endfunction

endpackage

`default_nettype wire

>>> rtl/kwlex_ifs.sv
`default_nettype none

// Source byte channel
interface kwlex_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] char_byte;

   modport source (output valid, output command, output char_byte, input ready);
   modport sink   (input valid, input command, input char_byte, output ready);
endinterface

// Token character channel
interface kwlex_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] token_type;
   logic [7:0] text_byte;
   logic       text_valid;
   logic       token_last;
   logic       text_truncated;
   logic       step_last;

   modport source (output valid, output token_type, output text_byte, output text_valid,
                   output token_last, output text_truncated, output step_last,
                   input ready);
   modport sink   (input valid, input token_type, input text_byte, input text_valid,
                   input token_last, input text_truncated, input step_last,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/keyword_lexer_tokenizer.sv
// Streaming keyword lexer.
// req_chan carries one transaction per source byte (command 0) or an end of
// source (command 1); rsp_chan carries one transaction per token character,
// with the token type and token_last/step_last marks. Both use valid/ready.
// The front classifies each byte against the lexer mode and posts zero to two
// operations (buffer append, single character, buffered text run) into a
// four-entry queue; the back executes them and owns the token text buffer.
// Input rate: one byte per cycle when it posts nothing; a byte that posts
// operations holds req_chan.ready low until the front has handed them all to
// the queue, and beyond that the front only stalls when the queue is full. On
// the output, a buffered text run is popped and then each character takes a
// registered buffer read and then a send, a single character is popped and
// then sent, and a buffer append is only popped. When rsp_chan is stalled the
// current result holds and the queue fills, after which req_chan.ready drops.
// Reset (synchronous) returns the lexer to idle, empties the queue and the
// back sequencer; buffer contents are not cleared and need no clearing pass.
`default_nettype none

module keyword_lexer_tokenizer #(
   parameter int MAX_TOKEN_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   kwlex_req_if.sink   req_chan,
   kwlex_rsp_if.source rsp_chan
);

   kwlex_pkg::uop_type front_data, back_data;
   logic               front_valid, front_ready, back_valid, back_ready;

   kwlex_front #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_data   (front_data),
      .q_valid  (front_valid),
      .q_ready  (front_ready)
   );

   kwlex_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_data   (front_data),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_data  (back_data),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   kwlex_back #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (back_data),
      .q_valid  (back_valid),
      .q_ready  (back_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

>>> rtl/kwlex_front.sv
`default_nettype none

module kwlex_front #(
   parameter int MAX_TOKEN_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   kwlex_req_if.sink         req_chan,
   output kwlex_pkg::uop_type q_data,
   output logic              q_valid,
   input  logic              q_ready
);

   localparam int LW = kwlex_pkg::TEXT_LEN_W;
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_TOKEN_LEN);

   kwlex_pkg::mode_type mode_ff, mode_in;
   logic [LW-1:0]       len_ff, len_in;
   logic                ovf_ff, ovf_in;
   logic [kwlex_pkg::KW_COUNT-1:0] kw_ff, kw_in;
   kwlex_pkg::uop_type  slot_ff [2];
   kwlex_pkg::uop_type  slot_in [2];
   logic [1:0]          pv_ff, pv_in;

   logic                accept, push;
   logic [7:0]          c;
   logic [3:0]          word_tt;
   logic [7:0]          pend_ch;
   kwlex_pkg::uop_type  flush_u, app_u, st_u, a_u, b_u, s0_u, s1_u;
   logic                flush_v, app_v, st_v, a_v, b_v, s1_v, cont;
   logic [LW-1:0]       len_app, st_len;
   logic                ovf_app;
   logic [kwlex_pkg::KW_COUNT-1:0] kw_app, st_kw;
   kwlex_pkg::mode_type st_mode;

   assign c        = req_chan.char_byte;
   assign accept   = req_chan.valid && req_chan.ready;
   assign push     = pv_ff[0] && q_ready;
   // a new transaction only once the previous one has left all its work in the queue
   assign req_chan.ready = !pv_ff[0];
   assign q_valid  = pv_ff[0];
   assign q_data   = slot_ff[0];

   always_comb begin
      // keyword match on the open word
      word_tt = kwlex_pkg::TOK_IDENT;
      if (!ovf_ff) begin
         for (int k = 0; k < kwlex_pkg::KW_COUNT; k++) begin
            if (kw_ff[k] && len_ff == kwlex_pkg::KW_LEN[k]) word_tt = 4'(k);
         end
      end

      // character of a pending one-byte operator
      unique case (mode_ff)
         kwlex_pkg::MODE_EQ:   pend_ch = kwlex_pkg::CH_EQUAL;
         kwlex_pkg::MODE_BANG: pend_ch = kwlex_pkg::CH_BANG;
         kwlex_pkg::MODE_GT:   pend_ch = kwlex_pkg::CH_GT;
         default:              pend_ch = kwlex_pkg::CH_LT;
      endcase

      // emit the open token
      flush_v = 1'b1;
      unique case (mode_ff)
         kwlex_pkg::MODE_IDLE: begin
            flush_v = 1'b0;
            flush_u = kwlex_pkg::make_text(kwlex_pkg::TOK_IDENT, len_ff, ovf_ff);
         end
         kwlex_pkg::MODE_WORD: flush_u = kwlex_pkg::make_text(word_tt, len_ff, ovf_ff);
         kwlex_pkg::MODE_NUM:
            flush_u = kwlex_pkg::make_text(kwlex_pkg::TOK_NUMBER, len_ff, ovf_ff);
         kwlex_pkg::MODE_STR:
            flush_u = kwlex_pkg::make_text(kwlex_pkg::TOK_STRING, len_ff, ovf_ff);
         kwlex_pkg::MODE_EQ:
            flush_u = kwlex_pkg::make_char(kwlex_pkg::TOK_ASSIGN, pend_ch, 1'b1, 1'b1);
         kwlex_pkg::MODE_BANG, kwlex_pkg::MODE_GT, kwlex_pkg::MODE_LT:
            flush_u = kwlex_pkg::make_char(kwlex_pkg::TOK_OP, pend_ch, 1'b1, 1'b1);
      endcase

      // append to the open token, drop and flag once the buffer is full
      app_v   = len_ff < MAX_LEN;
      app_u   = kwlex_pkg::make_append(len_ff, c);
      len_app = app_v ? len_ff + LW'(1) : len_ff;
      ovf_app = ovf_ff | !app_v;
      for (int k = 0; k < kwlex_pkg::KW_COUNT; k++) begin
         kw_app[k] = kw_ff[k] && (len_ff < LW'(kwlex_pkg::KW_MAX_LEN)) &&
                     (kwlex_pkg::KW_TEXT[k][len_ff[kwlex_pkg::KW_POS_W-1:0]] == c);
      end

      // byte seen from the idle mode
      st_mode = kwlex_pkg::MODE_IDLE;
      st_len  = '0;
      st_v    = 1'b0;
      st_u    = kwlex_pkg::make_append('0, c);
      for (int k = 0; k < kwlex_pkg::KW_COUNT; k++) begin
         st_kw[k] = (kwlex_pkg::KW_TEXT[k][0] == c);
      end
      priority if (kwlex_pkg::is_space(c)) begin
         st_mode = kwlex_pkg::MODE_IDLE;
      end else if (kwlex_pkg::is_alpha(c)) begin
         st_mode = kwlex_pkg::MODE_WORD;
         st_len  = LW'(1);
         st_v    = 1'b1;
      end else if (kwlex_pkg::is_digit(c)) begin
         st_mode = kwlex_pkg::MODE_NUM;
         st_len  = LW'(1);
         st_v    = 1'b1;
      end else if (c == kwlex_pkg::CH_QUOTE) begin
         st_mode = kwlex_pkg::MODE_STR;
      end else if (c == kwlex_pkg::CH_EQUAL) begin
         st_mode = kwlex_pkg::MODE_EQ;
      end else if (c == kwlex_pkg::CH_BANG) begin
         st_mode = kwlex_pkg::MODE_BANG;
      end else if (c == kwlex_pkg::CH_GT) begin
         st_mode = kwlex_pkg::MODE_GT;
      end else if (c == kwlex_pkg::CH_LT) begin
         st_mode = kwlex_pkg::MODE_LT;
      end else if (c == kwlex_pkg::CH_COLON) begin
         st_v = 1'b1;
         st_u = kwlex_pkg::make_char(kwlex_pkg::TOK_COLON, c, 1'b1, 1'b1);
      end else begin
         st_v = 1'b1;
         st_u = kwlex_pkg::make_char(kwlex_pkg::TOK_OP, c, 1'b1, 1'b1);
      end

      // pick up to two operations for this transaction
      a_u     = flush_u;
      a_v     = 1'b0;
      b_u     = st_u;
      b_v     = 1'b0;
      mode_in = mode_ff;
      len_in  = len_ff;
      ovf_in  = ovf_ff;
      kw_in   = kw_ff;
      cont    = 1'b0;
      if (req_chan.command) begin
         a_v     = flush_v;
         b_u     = kwlex_pkg::make_char(kwlex_pkg::TOK_EOF, kwlex_pkg::CH_NUL, 1'b0, 1'b1);
         b_v     = 1'b1;
         mode_in = kwlex_pkg::MODE_IDLE;
         len_in  = '0;
         ovf_in  = 1'b0;
         kw_in   = '0;
      end else begin
         unique case (mode_ff)
            kwlex_pkg::MODE_WORD, kwlex_pkg::MODE_NUM, kwlex_pkg::MODE_STR: begin
               if (mode_ff == kwlex_pkg::MODE_WORD) cont = kwlex_pkg::is_word_char(c);
               else if (mode_ff == kwlex_pkg::MODE_NUM)
                  cont = kwlex_pkg::is_digit(c) || (c == kwlex_pkg::CH_DOT);
               else cont = (c != kwlex_pkg::CH_QUOTE);
               if (cont) begin
                  a_u    = app_u;
                  a_v    = app_v;
                  len_in = len_app;
                  ovf_in = ovf_app;
                  kw_in  = kw_app;
               end else if (mode_ff == kwlex_pkg::MODE_STR) begin
                  // closing quote ends the string only
                  a_v     = 1'b1;
                  mode_in = kwlex_pkg::MODE_IDLE;
                  len_in  = '0;
                  ovf_in  = 1'b0;
                  kw_in   = '0;
               end else begin
                  a_v     = 1'b1;
                  b_v     = st_v;
                  mode_in = st_mode;
                  len_in  = st_len;
                  ovf_in  = 1'b0;
                  kw_in   = st_kw;
               end
            end
            kwlex_pkg::MODE_EQ, kwlex_pkg::MODE_BANG,
            kwlex_pkg::MODE_GT, kwlex_pkg::MODE_LT: begin
               if (c == kwlex_pkg::CH_EQUAL) begin
                  // two-character comparison
                  a_u     = kwlex_pkg::make_char(kwlex_pkg::TOK_OP, pend_ch, 1'b1, 1'b0);
                  a_v     = 1'b1;
                  b_u     = kwlex_pkg::make_char(kwlex_pkg::TOK_OP, c, 1'b1, 1'b1);
                  b_v     = 1'b1;
                  mode_in = kwlex_pkg::MODE_IDLE;
                  len_in  = '0;
                  ovf_in  = 1'b0;
                  kw_in   = '0;
               end else begin
                  a_v     = 1'b1;
                  b_v     = st_v;
                  mode_in = st_mode;
                  len_in  = st_len;
                  ovf_in  = 1'b0;
                  kw_in   = st_kw;
               end
            end
            kwlex_pkg::MODE_IDLE: begin
               a_u     = st_u;
               a_v     = st_v;
               mode_in = st_mode;
               len_in  = st_len;
               ovf_in  = 1'b0;
               kw_in   = st_kw;
            end
         endcase
      end

      // compact into the slots and mark the last result-producing operation
      s0_u = a_v ? a_u : b_u;
      s1_u = b_u;
      s1_v = a_v && b_v;
      if (s1_v && s1_u.kind != kwlex_pkg::UOP_APPEND) begin
         s1_u.step_last = 1'b1;
      end else if ((a_v || b_v) && s0_u.kind != kwlex_pkg::UOP_APPEND) begin
         s0_u.step_last = 1'b1;
      end

      // slot shift register
      slot_in = slot_ff;
      pv_in   = pv_ff;
      if (accept) begin
         slot_in[0] = s0_u;
         slot_in[1] = s1_u;
         pv_in      = {s1_v, a_v || b_v};
      end else if (push) begin
         slot_in[0] = slot_ff[1];
         pv_in      = {1'b0, pv_ff[1]};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= kwlex_pkg::MODE_IDLE;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
         kw_ff   <= '0;
         pv_ff   <= '0;
      end else begin
         pv_ff <= pv_in;
         if (accept) begin
            mode_ff <= mode_in;
            len_ff  <= len_in;
            ovf_ff  <= ovf_in;
            kw_ff   <= kw_in;
         end
      end
   end

   // pending operations
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

`ifndef SYNTHESIS
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      pv_ff[1] |-> pv_ff[0])
      else $error("second slot pending without the first");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= MAX_LEN)
      else $error("token length beyond buffer size");
`endif

endmodule

`default_nettype wire

>>> rtl/kwlex_queue.sv
`default_nettype none

module kwlex_queue (
   input  logic               clock,
   input  logic               reset,
   input  kwlex_pkg::uop_type in_data,
   input  logic               in_valid,
   output logic               in_ready,
   output kwlex_pkg::uop_type out_data,
   output logic               out_valid,
   input  logic               out_ready
);

   localparam int PW = kwlex_pkg::QUEUE_PTR_W;

   kwlex_pkg::uop_type ent_ff [kwlex_pkg::QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]        count_ff, count_in;
   logic               wr, rd;

   assign in_ready  = count_ff != (PW + 1)'(kwlex_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = ent_ff[rd_ptr_ff];
   assign wr        = in_valid && in_ready;
   assign rd        = out_valid && out_ready;

   // pointer and fill level
   always_comb begin
      wr_ptr_in = wr ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = rd ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr && !rd) count_in = count_ff + (PW + 1)'(1);
      else if (rd && !wr) count_in = count_ff - (PW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr) ent_ff[wr_ptr_ff] <= in_data;
   end

endmodule

`default_nettype wire

>>> rtl/kwlex_back.sv
`default_nettype none

module kwlex_back #(
   parameter int MAX_TOKEN_LEN = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  kwlex_pkg::uop_type q_data,
   input  logic               q_valid,
   output logic               q_ready,
   kwlex_rsp_if.source        rsp_chan
);

   localparam int LW    = kwlex_pkg::TEXT_LEN_W;
   localparam int IDX_W = $clog2(MAX_TOKEN_LEN);

   kwlex_pkg::back_state_type state_ff, state_in;
   kwlex_pkg::uop_type        cur_ff, cur_in;
   logic [LW-1:0]             idx_ff, idx_in;
   logic [7:0]                rd_data_ff;
   logic [7:0]                text_mem [MAX_TOKEN_LEN];

   logic       pop, wr_en, from_mem, last_char, tok_last, sent;
   logic [LW:0] idx_plus;

   assign q_ready   = state_ff == kwlex_pkg::BK_IDLE;
   assign pop       = q_valid && q_ready;
   assign from_mem  = cur_ff.kind == kwlex_pkg::UOP_TEXT && cur_ff.text_valid;
   assign idx_plus  = {1'b0, idx_ff} + (LW + 1)'(1);
   assign last_char = idx_plus == {1'b0, cur_ff.len};
   assign tok_last  = cur_ff.token_last && (!from_mem || last_char);
   assign sent      = rsp_chan.valid && rsp_chan.ready;

   // result port, straight from registers
   assign rsp_chan.valid          = state_ff == kwlex_pkg::BK_SEND;
   assign rsp_chan.token_type     = cur_ff.token_type;
   assign rsp_chan.text_byte      = from_mem ? rd_data_ff : cur_ff.data;
   assign rsp_chan.text_valid     = cur_ff.text_valid;
   assign rsp_chan.token_last     = tok_last;
   assign rsp_chan.text_truncated = cur_ff.trunc;
   assign rsp_chan.step_last      = cur_ff.step_last && tok_last;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      wr_en    = 1'b0;
      unique case (state_ff)
         kwlex_pkg::BK_IDLE: begin
            if (pop) begin
               cur_in = q_data;
               idx_in = '0;
               unique case (q_data.kind)
                  kwlex_pkg::UOP_APPEND: wr_en = 1'b1;
                  kwlex_pkg::UOP_TEXT:
                     state_in = q_data.text_valid ? kwlex_pkg::BK_READ : kwlex_pkg::BK_SEND;
                  default: state_in = kwlex_pkg::BK_SEND;
               endcase
            end
         end
         kwlex_pkg::BK_READ: state_in = kwlex_pkg::BK_SEND;
         kwlex_pkg::BK_SEND: begin
            if (sent) begin
               if (from_mem && !last_char) begin
                  idx_in   = idx_plus[LW-1:0];
                  state_in = kwlex_pkg::BK_READ;
               end else begin
                  state_in = kwlex_pkg::BK_IDLE;
               end
            end
         end
         default: state_in = kwlex_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= kwlex_pkg::BK_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
   end

   // token text buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) text_mem[q_data.len[IDX_W-1:0]] <= q_data.data;
      rd_data_ff <= text_mem[idx_ff[IDX_W-1:0]];
   end

`ifndef SYNTHESIS
   a_append_in_range: assert property (@(posedge clock) disable iff (reset)
      (pop && q_data.kind == kwlex_pkg::UOP_APPEND) |-> q_data.len < LW'(MAX_TOKEN_LEN))
      else $error("buffer write beyond token buffer");

   a_read_then_send: assert property (@(posedge clock) disable iff (reset)
      state_ff == kwlex_pkg::BK_READ |=> state_ff == kwlex_pkg::BK_SEND)
      else $error("buffer read not followed by send");

   a_idx_in_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kwlex_pkg::BK_SEND && from_mem) |-> idx_ff < cur_ff.len)
      else $error("drain index past token length");
`endif

endmodule

`default_nettype wire
